@@ rtl/core/clns_pkg.sv @@
package clns_pkg;

    localparam int unsigned CELL_PIXELS_DEF = 10;
    localparam int unsigned GRID_COLS_DEF   = 64;
    localparam int unsigned GRID_ROWS_DEF   = 64;
    localparam int unsigned MAX_POINTS_DEF  = 4096;

    // result cap per query and the width of its counter
    localparam int unsigned OUT_CAP = 64;
    localparam int unsigned CNT_W   = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 16;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_READ,
        ST_U_CHK,
        ST_UNL_WAIT,
        ST_UNL_WR,
        ST_LNK_WAIT,
        ST_LNK_RD,
        ST_LNK_W1,
        ST_LNK_W2,
        ST_Q_WAIT,
        ST_Q_CELL,
        ST_Q_HEAD,
        ST_W_CHK,
        ST_W_SQ,
        ST_W_CMP,
        ST_Q_END
    } state_t;

    typedef struct packed {
        logic       clr_step;
        logic       lat_in;
        logic       rd_pt_p;
        logic       rd_pt_q;
        logic       src_mem;
        logic       unlink_wr;
        logic       rd_head_new;
        logic       rd_head_nbr;
        logic       link_wr1;
        logic       link_wr2;
        logic       load_q_head;
        logic       adv_q;
        logic       take_hit;
        logic       set_ovf;
        logic       emit_final;
        logic [1:0] di;
        logic [1:0] dj;
    } ctl_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] in_op;
        logic       in_p_ok;
        logic       op_ins;
        logic       linked;
        logic       q_none;
        logic       hit;
        logic       cnt_full;
        logic       pend_valid;
        logic       out_free;
    } ctl_status_t;

endpackage

@@ rtl/core/clns_ctrl.sv @@
module clns_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  clns_pkg::ctl_status_t  st,
    output clns_pkg::ctl_cmd_t     cmd
);

    clns_pkg::state_t state_reg, state_next;
    logic [1:0] wait_reg, wait_next;
    logic [1:0] di_reg, di_next;
    logic [1:0] dj_reg, dj_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clns_pkg::ST_CLEAR;
            wait_reg  <= 2'd0;
            di_reg    <= 2'd0;
            dj_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            di_reg    <= di_next;
            dj_reg    <= dj_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = 2'd0;
        di_next    = di_reg;
        dj_next    = dj_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.di     = di_reg;
        cmd.dj     = dj_reg;
        unique case (state_reg)
            clns_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                    state_next = clns_pkg::ST_IDLE;
            end
            clns_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.lat_in = 1'b1;
                    if (st.in_op == clns_pkg::OP_QUERY)
                        state_next = clns_pkg::ST_Q_WAIT;
                    else if ((st.in_op == clns_pkg::OP_INSERT ||
                              st.in_op == clns_pkg::OP_REMOVE) && st.in_p_ok)
                        state_next = clns_pkg::ST_U_READ;
                end
            end
            clns_pkg::ST_U_READ:
            begin
                cmd.rd_pt_p = 1'b1;
                state_next  = clns_pkg::ST_U_CHK;
            end
            clns_pkg::ST_U_CHK:
            begin
                if (st.linked)
                    state_next = clns_pkg::ST_UNL_WAIT;
                else if (st.op_ins)
                    state_next = clns_pkg::ST_LNK_WAIT;
                else
                    state_next = clns_pkg::ST_IDLE;
            end
            clns_pkg::ST_UNL_WAIT:
            begin
                // cell of the stored position runs through the coordinate pipe
                cmd.src_mem = 1'b1;
                wait_next   = wait_reg + 2'd1;
                if (wait_reg == 2'd3)
                    state_next = clns_pkg::ST_UNL_WR;
            end
            clns_pkg::ST_UNL_WR:
            begin
                cmd.src_mem   = 1'b1;
                cmd.unlink_wr = 1'b1;
                state_next    = st.op_ins ? clns_pkg::ST_LNK_WAIT : clns_pkg::ST_IDLE;
            end
            clns_pkg::ST_LNK_WAIT:
            begin
                wait_next = wait_reg + 2'd1;
                if (wait_reg == 2'd3)
                    state_next = clns_pkg::ST_LNK_RD;
            end
            clns_pkg::ST_LNK_RD:
            begin
                cmd.rd_head_new = 1'b1;
                state_next      = clns_pkg::ST_LNK_W1;
            end
            clns_pkg::ST_LNK_W1:
            begin
                cmd.link_wr1 = 1'b1;
                state_next   = clns_pkg::ST_LNK_W2;
            end
            clns_pkg::ST_LNK_W2:
            begin
                cmd.link_wr2 = 1'b1;
                state_next   = clns_pkg::ST_IDLE;
            end
            clns_pkg::ST_Q_WAIT:
            begin
                wait_next = wait_reg + 2'd1;
                di_next   = 2'd0;
                dj_next   = 2'd0;
                if (wait_reg == 2'd3)
                    state_next = clns_pkg::ST_Q_CELL;
            end
            clns_pkg::ST_Q_CELL:
            begin
                cmd.rd_head_nbr = 1'b1;
                state_next      = clns_pkg::ST_Q_HEAD;
            end
            clns_pkg::ST_Q_HEAD:
            begin
                cmd.load_q_head = 1'b1;
                state_next      = clns_pkg::ST_W_CHK;
            end
            clns_pkg::ST_W_CHK:
            begin
                if (!st.q_none)
                begin
                    cmd.rd_pt_q = 1'b1;
                    state_next  = clns_pkg::ST_W_SQ;
                end
                else if (di_reg == 2'd2 && dj_reg == 2'd2)
                    state_next = clns_pkg::ST_Q_END;
                else
                begin
                    // advance to the next cell, row by row
                    if (di_reg == 2'd2)
                    begin
                        di_next = 2'd0;
                        dj_next = dj_reg + 2'd1;
                    end
                    else
                        di_next = di_reg + 2'd1;
                    state_next = clns_pkg::ST_Q_CELL;
                end
            end
            clns_pkg::ST_W_SQ:
            begin
                state_next = clns_pkg::ST_W_CMP;
            end
            clns_pkg::ST_W_CMP:
            begin
                priority if (!st.hit)
                begin
                    cmd.adv_q  = 1'b1;
                    state_next = clns_pkg::ST_W_CHK;
                end
                else if (st.cnt_full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = clns_pkg::ST_Q_END;
                end
                else if (!st.pend_valid || st.out_free)
                begin
                    cmd.take_hit = 1'b1;
                    cmd.adv_q    = 1'b1;
                    state_next   = clns_pkg::ST_W_CHK;
                end
                else
                    state_next = clns_pkg::ST_W_CMP;
            end
            clns_pkg::ST_Q_END:
            begin
                if (st.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = clns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clns_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/clns_dpath.sv @@
module clns_dpath
#(
    parameter int unsigned CELL_PIXELS = clns_pkg::CELL_PIXELS_DEF,
    parameter int unsigned GRID_COLS   = clns_pkg::GRID_COLS_DEF,
    parameter int unsigned GRID_ROWS   = clns_pkg::GRID_ROWS_DEF,
    parameter int unsigned MAX_POINTS  = clns_pkg::MAX_POINTS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  clns_pkg::ctl_cmd_t                   cmd,
    output clns_pkg::ctl_status_t                st,
    input  logic [clns_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [1:0]                           s_tuser,
    input  logic                                 radius_sq_we,
    input  logic [31:0]                          radius_sq_wdata,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [clns_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    localparam int unsigned NC    = GRID_COLS * GRID_ROWS;
    localparam int unsigned CAW   = $clog2(NC);
    localparam int unsigned PAW   = $clog2(MAX_POINTS);
    localparam int unsigned LW    = PAW + 1;
    localparam int unsigned CXW   = $clog2(GRID_COLS);
    localparam int unsigned CYW   = $clog2(GRID_ROWS);
    localparam int unsigned CLR_N = (NC > MAX_POINTS) ? NC : MAX_POINTS;
    localparam int unsigned CLW   = $clog2(CLR_N);
    localparam int unsigned DSH   = 20;
    localparam int unsigned M_PIX = ((1 << DSH) + CELL_PIXELS - 1) / CELL_PIXELS;
    localparam int unsigned M_COL = ((1 << DSH) + GRID_COLS - 1) / GRID_COLS;
    localparam int unsigned M_ROW = ((1 << DSH) + GRID_ROWS - 1) / GRID_ROWS;
    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_POINTS);

    logic [LW-1:0] head_mem   [NC];
    logic [LW-1:0] next_mem   [MAX_POINTS];
    logic [LW-1:0] prev_mem   [MAX_POINTS];
    logic [15:0]   x_mem      [MAX_POINTS];
    logic [15:0]   y_mem      [MAX_POINTS];
    logic          linked_mem [MAX_POINTS];

    logic [LW-1:0] head_rd_reg, next_rd_reg, prev_rd_reg;
    logic [15:0]   x_rd_reg, y_rd_reg;
    logic          linked_rd_reg;

    logic [CLW-1:0] clr_reg;
    logic [31:0]    radius_reg;
    logic [1:0]     op_reg;
    logic [11:0]    p_reg;
    logic [15:0]    x_in_reg, y_in_reg;
    logic [11:0]    lo_reg;
    logic [12:0]    skcnt_reg;

    logic [9:0]     qx1_reg, qy1_reg, qx2_reg, qy2_reg;
    logic [CXW-1:0] cx_reg;
    logic [CYW-1:0] cy_reg;
    logic [CAW-1:0] cell_reg;

    logic [LW-1:0]  q_reg;
    logic [31:0]    sqx_reg, sqy_reg;
    logic [11:0]    pend_idx_reg;
    logic           pend_valid_reg;
    logic [clns_pkg::CNT_W-1:0] count_reg;
    logic           ovf_reg;

    logic           m_valid_reg;
    logic [11:0]    m_idx_reg;
    logic           m_found_reg, m_last_reg, m_ovf_reg;

    // coordinate pipe
    logic [15:0] src_x, src_y;
    logic [31:0] prod_x1, prod_y1, prod_x2, prod_y2, rem_x, rem_y, cell_w;

    always_comb
    begin
        src_x   = cmd.src_mem ? x_rd_reg : x_in_reg;
        src_y   = cmd.src_mem ? y_rd_reg : y_in_reg;
        prod_x1 = 32'(src_x[15:6]) * 32'(M_PIX);
        prod_y1 = 32'(src_y[15:6]) * 32'(M_PIX);
        prod_x2 = 32'(qx1_reg) * 32'(M_COL);
        prod_y2 = 32'(qy1_reg) * 32'(M_ROW);
        rem_x   = 32'(qx1_reg) - 32'(qx2_reg) * 32'(GRID_COLS);
        rem_y   = 32'(qy1_reg) - 32'(qy2_reg) * 32'(GRID_ROWS);
        cell_w  = 32'(cx_reg) + 32'(cy_reg) * 32'(GRID_COLS);
    end

    always_ff @(posedge clk)
    begin
        qx1_reg  <= prod_x1[DSH+9:DSH];
        qy1_reg  <= prod_y1[DSH+9:DSH];
        qx2_reg  <= prod_x2[DSH+9:DSH];
        qy2_reg  <= prod_y2[DSH+9:DSH];
        cx_reg   <= rem_x[CXW-1:0];
        cy_reg   <= rem_y[CYW-1:0];
        cell_reg <= cell_w[CAW-1:0];
    end

    // wrapped neighbor cell
    logic [CXW-1:0] ncx;
    logic [CYW-1:0] ncy;
    logic [31:0]    nb_w;

    always_comb
    begin
        unique case (cmd.di)
            2'd0:    ncx = (cx_reg == '0) ? CXW'(GRID_COLS - 1) : cx_reg - CXW'(1);
            2'd2:    ncx = (cx_reg == CXW'(GRID_COLS - 1)) ? '0 : cx_reg + CXW'(1);
            default: ncx = cx_reg;
        endcase
        unique case (cmd.dj)
            2'd0:    ncy = (cy_reg == '0) ? CYW'(GRID_ROWS - 1) : cy_reg - CYW'(1);
            2'd2:    ncy = (cy_reg == CYW'(GRID_ROWS - 1)) ? '0 : cy_reg + CYW'(1);
            default: ncy = cy_reg;
        endcase
        nb_w = 32'(ncx) + 32'(ncy) * 32'(GRID_COLS);
    end

    // memory port muxes
    logic [31:0]    p_w, q_w, clr_w;
    logic [PAW-1:0] p_addr;
    logic [LW-1:0]  p_link;
    logic           pv_none, nx_none, h_none;

    logic           head_we, head_re;
    logic [CAW-1:0] head_waddr, head_raddr;
    logic [LW-1:0]  head_wdata;
    logic           lk_we, lk_wdata;
    logic [PAW-1:0] lk_waddr;
    logic           nx_we, pv_we, pt_re;
    logic [PAW-1:0] nx_waddr, pv_waddr, pt_raddr;
    logic [LW-1:0]  nx_wdata, pv_wdata;

    always_comb
    begin
        p_w     = 32'(p_reg);
        q_w     = 32'(q_reg);
        clr_w   = 32'(clr_reg);
        p_addr  = p_w[PAW-1:0];
        p_link  = p_w[LW-1:0];
        pv_none = (prev_rd_reg == LINK_NONE);
        nx_none = (next_rd_reg == LINK_NONE);
        h_none  = (head_rd_reg == LINK_NONE);

        head_we    = 1'b0;
        head_waddr = cell_reg;
        head_wdata = p_link;
        if (cmd.clr_step && clr_w < NC)
        begin
            head_we    = 1'b1;
            head_waddr = clr_reg[CAW-1:0];
            head_wdata = LINK_NONE;
        end
        else if (cmd.unlink_wr && pv_none)
        begin
            head_we    = 1'b1;
            head_wdata = next_rd_reg;
        end
        else if (cmd.link_wr2)
            head_we = 1'b1;

        head_re    = cmd.rd_head_new | cmd.rd_head_nbr;
        head_raddr = cmd.rd_head_nbr ? nb_w[CAW-1:0] : cell_reg;

        lk_we    = 1'b0;
        lk_waddr = p_addr;
        lk_wdata = 1'b0;
        if (cmd.clr_step && clr_w < MAX_POINTS)
        begin
            lk_we    = 1'b1;
            lk_waddr = clr_reg[PAW-1:0];
        end
        else if (cmd.unlink_wr)
            lk_we = 1'b1;
        else if (cmd.link_wr2)
        begin
            lk_we    = 1'b1;
            lk_wdata = 1'b1;
        end

        nx_we    = 1'b0;
        nx_waddr = p_addr;
        nx_wdata = head_rd_reg;
        if (cmd.unlink_wr && !pv_none)
        begin
            nx_we    = 1'b1;
            nx_waddr = prev_rd_reg[PAW-1:0];
            nx_wdata = next_rd_reg;
        end
        else if (cmd.link_wr1)
            nx_we = 1'b1;

        pv_we    = 1'b0;
        pv_waddr = p_addr;
        pv_wdata = LINK_NONE;
        if (cmd.unlink_wr && !nx_none)
        begin
            pv_we    = 1'b1;
            pv_waddr = next_rd_reg[PAW-1:0];
            pv_wdata = prev_rd_reg;
        end
        else if (cmd.link_wr1)
            pv_we = 1'b1;
        else if (cmd.link_wr2 && !h_none)
        begin
            pv_we    = 1'b1;
            pv_waddr = head_rd_reg[PAW-1:0];
            pv_wdata = p_link;
        end

        pt_re    = cmd.rd_pt_p | cmd.rd_pt_q;
        pt_raddr = cmd.rd_pt_q ? q_reg[PAW-1:0] : p_addr;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        if (head_re)
            head_rd_reg <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
            linked_mem[lk_waddr] <= lk_wdata;
        if (pt_re)
            linked_rd_reg <= linked_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_waddr] <= nx_wdata;
        if (pt_re)
            next_rd_reg <= next_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            prev_mem[pv_waddr] <= pv_wdata;
        if (pt_re)
            prev_rd_reg <= prev_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_wr1)
        begin
            x_mem[p_addr] <= x_in_reg;
            y_mem[p_addr] <= y_in_reg;
        end
        if (pt_re)
        begin
            x_rd_reg <= x_mem[pt_raddr];
            y_rd_reg <= y_mem[pt_raddr];
        end
    end

    // input item and config
    always_ff @(posedge clk)
    begin
        if (cmd.lat_in)
        begin
            op_reg    <= s_tuser;
            p_reg     <= s_tdata[11:0];
            x_in_reg  <= s_tdata[27:12];
            y_in_reg  <= s_tdata[43:28];
            lo_reg    <= s_tdata[55:44];
            skcnt_reg <= s_tdata[68:56];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 32'd0;
            clr_reg    <= '0;
        end
        else
        begin
            if (radius_sq_we)
                radius_reg <= radius_sq_wdata;
            if (cmd.clr_step)
                clr_reg <= clr_reg + CLW'(1);
        end
    end

    // distance test
    logic [15:0] dx, dy;
    logic [32:0] dist_sum;
    logic [31:0] lo_w, hi_w;
    logic        skip_hit, hit;

    always_comb
    begin
        dx       = (x_in_reg > x_rd_reg) ? x_in_reg - x_rd_reg : x_rd_reg - x_in_reg;
        dy       = (y_in_reg > y_rd_reg) ? y_in_reg - y_rd_reg : y_rd_reg - y_in_reg;
        dist_sum = 33'(sqx_reg) + 33'(sqy_reg);
        lo_w     = 32'(lo_reg);
        hi_w     = lo_w + 32'(skcnt_reg);
        skip_hit = (q_w >= lo_w) && (q_w < hi_w);
        hit      = !skip_hit && (dist_sum < 33'(radius_reg));
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= 32'(dx) * 32'(dx);
        sqy_reg <= 32'(dy) * 32'(dy);
        if (cmd.load_q_head)
            q_reg <= head_rd_reg;
        else if (cmd.adv_q)
            q_reg <= next_rd_reg;
        if (cmd.take_hit)
            pend_idx_reg <= q_w[11:0];
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.lat_in)
            begin
                pend_valid_reg <= 1'b0;
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
            end
            else if (cmd.take_hit)
            begin
                pend_valid_reg <= 1'b1;
                count_reg      <= count_reg + clns_pkg::CNT_W'(1);
            end
            if (cmd.set_ovf)
                ovf_reg <= 1'b1;
            if ((cmd.take_hit && pend_valid_reg) || cmd.emit_final)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // flush the held hit, or close the query
    always_ff @(posedge clk)
    begin
        if (cmd.take_hit && pend_valid_reg)
        begin
            m_idx_reg   <= pend_idx_reg;
            m_found_reg <= 1'b1;
            m_last_reg  <= 1'b0;
            m_ovf_reg   <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            m_idx_reg   <= pend_valid_reg ? pend_idx_reg : 12'd0;
            m_found_reg <= pend_valid_reg;
            m_last_reg  <= 1'b1;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_idx_reg};
    assign m_tuser  = {m_ovf_reg, m_found_reg};
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        st.clr_done   = (clr_w == CLR_N - 1);
        st.in_op      = s_tuser;
        st.in_p_ok    = (32'(s_tdata[11:0]) < MAX_POINTS);
        st.op_ins     = (op_reg == clns_pkg::OP_INSERT);
        st.linked     = linked_rd_reg;
        st.q_none     = (q_reg == LINK_NONE);
        st.hit        = hit;
        st.cnt_full   = (32'(count_reg) == clns_pkg::OUT_CAP);
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
    end

endmodule

@@ rtl/core/cell_list_neighbor_search_unit.sv @@
// Channel   Dir  Accepted when          Contents
// s_*       in   s_tvalid & s_tready    tdata/tuser item: op, point, position, skip range
// m_*       out  m_tvalid & m_tready    tdata/tuser item: neighbor index, found, overflow
// radius_sq in   radius_sq_we           squared radius, no read-back
//
// Insert and remove read the point memories, run each position through the cell
// coordinate pipe, then do the link writes. A query walks the list of each of the
// nine neighbor cells entry by entry.
// After reset a clearing pass over max(cells, points) entries (4096 by default) empties
// the cell heads and linked flags; no item is accepted during it.
// A stalled output stalls the list walk only when a second hit is waiting, and holds
// the closing item until the output register frees.
module cell_list_neighbor_search_unit
#(
    parameter int unsigned CELL_PIXELS = clns_pkg::CELL_PIXELS_DEF,
    parameter int unsigned GRID_COLS   = clns_pkg::GRID_COLS_DEF,
    parameter int unsigned GRID_ROWS   = clns_pkg::GRID_ROWS_DEF,
    parameter int unsigned MAX_POINTS  = clns_pkg::MAX_POINTS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_index, pos_x, pos_y, skip_first, skip_count, zero pad
    input  logic [clns_pkg::IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [1:0]                      s_tuser,
    input  logic                            radius_sq_we,
    input  logic [31:0]                     radius_sq_wdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // neighbor_index, zero pad
    output logic [clns_pkg::OUT_DATA_W-1:0] m_tdata,
    // found, overflow
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    clns_pkg::ctl_cmd_t    cmd;
    clns_pkg::ctl_status_t st;

    clns_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    clns_dpath
    #(
        .CELL_PIXELS (CELL_PIXELS),
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS),
        .MAX_POINTS  (MAX_POINTS)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .radius_sq_we    (radius_sq_we),
        .radius_sq_wdata (radius_sq_wdata),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast)
    );

endmodule

@@ rtl/core/clns_checker.sv @@
module clns_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [clns_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            m_tlast
);

    // an empty answer is a single closing item with a zero index
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && !m_tuser[1] && m_tdata == '0))
        else $error("not-found item malformed");

    // overflow only on the closing item of a non-empty answer
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0]))
        else $error("overflow outside final item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output item changed");

endmodule

bind cell_list_neighbor_search_unit clns_checker u_clns_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int unsigned NPTS      = 4096;
    localparam int unsigned LINK_NONE = 4096;
    localparam int unsigned TIMEOUT   = 2000000;
    localparam int unsigned SETTLE    = 64;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [11:0] idx;
        logic        found;
        logic        last;
        logic        ovf;
    } hit_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // point_index, pos_x, pos_y, skip_first, skip_count, zero pad
    logic [71:0] s_tdata;
    // op
    logic [1:0]  s_tuser;
    logic        radius_sq_we;
    logic [31:0] radius_sq_wdata;
    logic        m_tvalid;
    logic        m_tready;
    // neighbor_index, zero pad
    logic [15:0] m_tdata;
    // found, overflow
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // local copy of the grid
    int unsigned head_of[NPTS];
    int unsigned nxt[NPTS];
    int unsigned prv[NPTS];
    int unsigned px[NPTS];
    int unsigned py[NPTS];
    bit          linked[NPTS];
    logic [31:0] radius;

    hit_t        pending_hits[$];
    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned hold_off;

    cell_list_neighbor_search_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .radius_sq_we    (radius_sq_we),
        .radius_sq_wdata (radius_sq_wdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned cell_index(int unsigned x, int unsigned y);
        return (((x >> 6) / 10) % 64) + (((y >> 6) / 10) % 64) * 64;
    endfunction

    function automatic void unlink_pt(int unsigned p);
        int unsigned c;
        c = cell_index(px[p], py[p]);
        if (prv[p] < NPTS)
            nxt[prv[p]] = nxt[p];
        else
            head_of[c] = nxt[p];
        if (nxt[p] < NPTS)
            prv[nxt[p]] = prv[p];
        linked[p] = 1'b0;
    endfunction

    // update the grid and queue the hits that one item must produce
    function automatic void predict_search(logic [1:0] op, int unsigned p, int unsigned x,
                                           int unsigned y, int unsigned lo, int unsigned cnt);
        int unsigned cx, cy, c, q, steps, count;
        longint unsigned dx, dy, hi;
        bit          ovf;
        hit_t        h;
        hit_t        found_hits[$];
        if (op == clns_pkg::OP_INSERT || op == clns_pkg::OP_REMOVE)
        begin
            if (linked[p])
                unlink_pt(p);
            if (op == clns_pkg::OP_INSERT)
            begin
                c = cell_index(x, y);
                px[p] = x;
                py[p] = y;
                nxt[p] = head_of[c];
                prv[p] = LINK_NONE;
                if (head_of[c] < NPTS)
                    prv[head_of[c]] = p;
                head_of[c] = p;
                linked[p] = 1'b1;
            end
            return;
        end
        if (op != clns_pkg::OP_QUERY)
            return;
        hi = longint'(lo) + cnt;
        cx = ((x >> 6) / 10) % 64;
        cy = ((y >> 6) / 10) % 64;
        ovf = 1'b0;
        count = 0;
        for (int j = 0; j < 3 && !ovf; j++)
        begin
            for (int i = 0; i < 3 && !ovf; i++)
            begin
                q = head_of[((cx + 63 + i) % 64) + ((cy + 63 + j) % 64) * 64];
                for (steps = 0; q < NPTS && steps < NPTS; steps++)
                begin
                    if (!(q >= lo && q < hi))
                    begin
                        dx = (x > px[q]) ? x - px[q] : px[q] - x;
                        dy = (y > py[q]) ? y - py[q] : py[q] - y;
                        if (dx * dx + dy * dy < longint'(radius))
                        begin
                            if (count == clns_pkg::OUT_CAP)
                            begin
                                ovf = 1'b1;
                                break;
                            end
                            h.idx = q[11:0];
                            h.found = 1'b1;
                            h.last = 1'b0;
                            h.ovf = 1'b0;
                            found_hits = {found_hits, h};
                            count++;
                        end
                    end
                    q = nxt[q];
                end
            end
        end
        if (count == 0)
        begin
            h = '0;
            h.last = 1'b1;
            found_hits = {found_hits, h};
        end
        else
        begin
            found_hits[count-1].last = 1'b1;
            found_hits[count-1].ovf = ovf;
        end
        pending_hits = {pending_hits, found_hits};
    endfunction

    task automatic send_item(logic [1:0] op, int unsigned p, int unsigned x, int unsigned y,
                             int unsigned lo, int unsigned cnt);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser = op;
        s_tdata = {3'b0, cnt[12:0], lo[11:0], y[15:0], x[15:0], p[11:0]};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_search(op, p, x, y, lo, cnt);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        // insert and remove give no result; let them finish
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_radius(logic [31:0] r);
        drain();
        radius_sq_we = 1'b1;
        radius_sq_wdata = r;
        @(negedge clk);
        radius_sq_we = 1'b0;
        radius = r;
    endtask

    task automatic test_directed();
        set_radius(32'd0);
        send_item(clns_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        set_radius(32'hFFFF_FFFF);
        send_item(clns_pkg::OP_QUERY, 0, 40959, 40959, 0, 0);
        send_item(clns_pkg::OP_INSERT, 0, 0, 0, 0, 0);
        send_item(clns_pkg::OP_INSERT, 4095, 40959, 40959, 0, 0);
        send_item(clns_pkg::OP_INSERT, 1, 640, 0, 0, 0);
        send_item(clns_pkg::OP_INSERT, 2, 0, 40959, 0, 0);
        send_item(clns_pkg::OP_INSERT, 2730, 39000, 100, 0, 0);
        // wrapped neighbors across both corners
        send_item(clns_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        send_item(clns_pkg::OP_QUERY, 0, 40959, 40959, 4095, 4096);
        send_item(clns_pkg::OP_QUERY, 0, 300, 300, 0, 4096);
        send_item(clns_pkg::OP_QUERY, 0, 300, 300, 1, 1);
        send_item(clns_pkg::OP_QUERY, 0, 300, 300, 1365, 2730);
        // re-insert a linked point, remove one not linked
        send_item(clns_pkg::OP_INSERT, 0, 700, 20, 0, 0);
        send_item(clns_pkg::OP_REMOVE, 3, 0, 0, 0, 0);
        send_item(clns_pkg::OP_REMOVE, 4095, 0, 0, 0, 0);
        send_item(OP_UNUSED, 1365, 21845, 21845, 1365, 5461);
        send_item(clns_pkg::OP_QUERY, 0, 40959, 40959, 0, 0);
        send_item(clns_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        set_radius(32'd1_000_000);
        send_item(clns_pkg::OP_QUERY, 0, 640, 0, 0, 0);
        send_item(clns_pkg::OP_REMOVE, 1, 0, 0, 0, 0);
        send_item(clns_pkg::OP_QUERY, 0, 640, 0, 0, 0);
    endtask

    task automatic test_random(int unsigned idle, int unsigned stall, int unsigned n);
        int unsigned op_pick, p, x, y, bx, by;
        logic [1:0]  op;
        src_idle_pct = idle;
        snk_stall_pct = stall;
        set_radius($urandom_range(3, 0) == 0 ? $urandom() : $urandom_range(4_000_000, 1));
        bx = $urandom_range(40959 - 2600);
        by = $urandom_range(40959 - 2600);
        for (int k = 0; k < n; k++)
        begin
            op_pick = $urandom_range(99);
            if (op_pick < 45)
                op = clns_pkg::OP_INSERT;
            else if (op_pick < 65)
                op = clns_pkg::OP_REMOVE;
            else if (op_pick < 97)
                op = clns_pkg::OP_QUERY;
            else
                op = OP_UNUSED;
            p = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(47);
            if ($urandom_range(9) == 0)
            begin
                x = $urandom_range(40959);
                y = $urandom_range(40959);
            end
            else
            begin
                x = bx + $urandom_range(2600);
                y = by + $urandom_range(2600);
            end
            send_item(op, p, x, y, $urandom_range(4095),
                      $urandom_range(1) ? $urandom_range(8) : $urandom_range(4096));
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        set_radius(32'hFFFF_FFFF);
        for (int k = 0; k < 70; k++)
            send_item(clns_pkg::OP_INSERT, 100 + k, 20000 + $urandom_range(600),
                      20000 + $urandom_range(600), 0, 0);
        drain();
        // stall the output long enough for the input to back up
        hold_off = 600;
        for (int k = 0; k < 4; k++)
            send_item(clns_pkg::OP_QUERY, 0, 20300, 20300, 100 + k, k);
        drain();
        send_item(clns_pkg::OP_QUERY, 0, 20300, 20300, 100, 10);
        drain();
    endtask

    always @(negedge clk)
    begin
        if (hold_off != 0)
        begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected item: idx %0d found %b last %b ovf %b",
                             m_tdata[11:0], m_tuser[0], m_tlast, m_tuser[1]);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (m_tdata !== {4'b0, want.idx} || m_tuser[0] !== want.found ||
                    m_tlast !== want.last || m_tuser[1] !== want.ovf)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("item differs: idx %0d/%0d found %b/%b last %b/%b ovf %b/%b",
                                 want.idx, m_tdata, want.found, m_tuser[0],
                                 want.last, m_tlast, want.ovf, m_tuser[1]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT)
        begin
            $display("cell_list_neighbor_search_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        radius_sq_we = 1'b0;
        radius_sq_wdata = '0;
        m_tready = 1'b0;
        err_count = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_off = 0;
        radius = '0;
        for (int k = 0; k < NPTS; k++)
        begin
            head_of[k] = LINK_NONE;
            nxt[k] = 0;
            prv[k] = 0;
            px[k] = 0;
            py[k] = 0;
            linked[k] = 1'b0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(0, 0, 30);
        test_random(45, 0, 30);
        test_random(0, 45, 30);
        test_random(26, 26, 30);
        test_backpressure();
        drain();
        repeat (200) @(negedge clk);
        if (err_count == 0 && pending_hits.size() == 0)
            $display("cell_list_neighbor_search_unit: match");
        else
            $display("cell_list_neighbor_search_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/clns_pkg.sv
rtl/core/clns_ctrl.sv
rtl/core/clns_dpath.sv
rtl/core/cell_list_neighbor_search_unit.sv
rtl/core/clns_checker.sv
tb/sv/tb.sv
